@@ rtl/hua_pkg.sv @@
// ----------------------------------------------------------------------------
// hua_pkg
// Shared types and constants for the first-fit heap unit allocator.
// ----------------------------------------------------------------------------
package hua_pkg;

    localparam int UNIT_BYTES  = 128;
    localparam int UNIT_COUNT  = 64;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
    localparam int HEAP_BYTES  = UNIT_BYTES * UNIT_COUNT;
    localparam int IDX_W       = $clog2(UNIT_COUNT);
    localparam int ENTRY_W     = 7;
    localparam int BYTES_W     = 16;
    localparam int OFF_W       = 13;
    localparam int WANT_W      = BYTES_W + 1 - UNIT_SHIFT;
    localparam int POS_W       = WANT_W + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOMEM  = 2'd1,
        ST_BADPTR = 2'd2
    } status_t;

    typedef struct packed {
        logic               kind;
        logic [BYTES_W-1:0] request_bytes;
        logic [BYTES_W-1:0] block_offset;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   granted_offset;
    } rsp_t;

    typedef struct packed {
        logic idle;
        logic done;
        rsp_t result;
    } ctrl_stat_t;

endpackage

@@ rtl/hua_ram.sv @@
// ----------------------------------------------------------------------------
// hua_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hua_ctrl.sv @@
// ----------------------------------------------------------------------------
// hua_ctrl
// Map sequencer: walks the unit map one entry per cycle through a shared
// adder, marks allocated runs and clears freed ones.
// ----------------------------------------------------------------------------
module hua_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hua_pkg::req_t       req,
    input  logic                take,
    output hua_pkg::ctrl_stat_t stat
);

    localparam int BYTES_SUM_W = hua_pkg::BYTES_W + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AHEAD = 7'b0000010,
        S_ARUN  = 7'b0000100,
        S_MARK  = 7'b0001000,
        S_FHEAD = 7'b0010000,
        S_FCLR  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [hua_pkg::POS_W-1:0]       i_reg, i_next;
    logic [hua_pkg::POS_W-1:0]       n_reg, n_next;
    logic [hua_pkg::POS_W-1:0]       k_reg, k_next;
    logic [hua_pkg::POS_W-1:0]       end_reg, end_next;
    logic [hua_pkg::WANT_W-1:0]      want_reg, want_next;
    hua_pkg::rsp_t                   res_reg, res_next;
    logic [hua_pkg::UNIT_COUNT-1:0]  valid_reg, valid_next;
    logic                            rdv_reg;

    logic [hua_pkg::IDX_W-1:0]       rd_addr;
    logic                            we;
    logic [hua_pkg::ENTRY_W-1:0]     wdata;
    logic [hua_pkg::ENTRY_W-1:0]     ram_q;
    logic [hua_pkg::ENTRY_W-1:0]     entry;
    logic [hua_pkg::POS_W-1:0]       entry_ext;

    logic [hua_pkg::POS_W-1:0]       add_a, add_b, add_sum;
    logic [hua_pkg::POS_W-1:0]       inc_in, inc_out;
    logic [hua_pkg::POS_W-1:0]       k_inc;
    logic [hua_pkg::POS_W-1:0]       run_end;
    logic [hua_pkg::POS_W-1:0]       unit_lim;

    logic [BYTES_SUM_W-1:0]          bytes_sum;
    logic [hua_pkg::WANT_W-1:0]      want_in;
    logic                            bad_ptr;
    logic [hua_pkg::POS_W-1:0]       free_idx;

    hua_ram #(
        .WIDTH (hua_pkg::ENTRY_W),
        .DEPTH (hua_pkg::UNIT_COUNT)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (k_reg[hua_pkg::IDX_W-1:0]),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign entry     = rdv_reg ? ram_q : '0;
    assign entry_ext = hua_pkg::POS_W'(entry);
    assign unit_lim  = hua_pkg::POS_W'(hua_pkg::UNIT_COUNT);

    // request decode
    assign bytes_sum  = BYTES_SUM_W'(req.request_bytes) + BYTES_SUM_W'(hua_pkg::UNIT_BYTES - 1);
    assign want_in    = hua_pkg::WANT_W'(bytes_sum >> hua_pkg::UNIT_SHIFT);
    assign bad_ptr    = (32'(req.block_offset) >= hua_pkg::HEAP_BYTES) ||
                        (req.block_offset[hua_pkg::UNIT_SHIFT-1:0] != '0);
    assign free_idx   = hua_pkg::POS_W'(req.block_offset >> hua_pkg::UNIT_SHIFT);

    // shared adder and incrementers
    always_comb
    begin
        add_a  = i_reg;
        add_b  = entry_ext;
        inc_in = i_reg;
        case (state_reg)
            S_AHEAD:
            begin
                add_a  = i_reg;
                add_b  = (entry == '0) ? hua_pkg::POS_W'(want_reg) : entry_ext;
                inc_in = i_reg;
            end
            S_ARUN:
            begin
                inc_in = n_reg;
            end
            S_FHEAD:
            begin
                add_a = k_reg;
                add_b = entry_ext;
            end
            default:
            begin
                add_a  = i_reg;
                add_b  = entry_ext;
                inc_in = i_reg;
            end
        endcase
    end

    assign add_sum = add_a + add_b;
    assign inc_out = inc_in + hua_pkg::POS_W'(1);
    assign k_inc   = k_reg + hua_pkg::POS_W'(1);
    assign run_end = (state_reg == S_AHEAD) ? add_sum : end_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        end_next   = end_reg;
        want_next  = want_reg;
        res_next   = res_reg;
        valid_next = valid_reg;
        rd_addr    = '0;
        we         = 1'b0;
        wdata      = hua_pkg::ENTRY_W'(end_reg - k_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.kind == hua_pkg::KIND_ALLOC)
                    begin
                        want_next  = want_in;
                        i_next     = '0;
                        rd_addr    = '0;
                        state_next = S_AHEAD;
                    end
                    else if (bad_ptr)
                    begin
                        res_next.status         = hua_pkg::ST_BADPTR;
                        res_next.granted_offset = '0;
                        state_next              = S_DONE;
                    end
                    else
                    begin
                        k_next     = free_idx;
                        rd_addr    = free_idx[hua_pkg::IDX_W-1:0];
                        state_next = S_FHEAD;
                    end
                end
            end
            S_AHEAD, S_ARUN:
            begin
                if (entry == '0 && state_reg == S_AHEAD && want_reg == '0)
                begin
                    res_next.status         = hua_pkg::ST_OK;
                    res_next.granted_offset =
                        hua_pkg::OFF_W'({i_reg, {hua_pkg::UNIT_SHIFT{1'b0}}});
                    state_next              = S_DONE;
                end
                else if (entry == '0)
                begin
                    if (state_reg == S_AHEAD)
                    begin
                        end_next = add_sum;
                    end
                    if (inc_out == run_end)
                    begin
                        k_next     = i_reg;
                        end_next   = run_end;
                        state_next = S_MARK;
                    end
                    else if (inc_out >= unit_lim)
                    begin
                        res_next.status         = hua_pkg::ST_NOMEM;
                        res_next.granted_offset = '0;
                        state_next              = S_DONE;
                    end
                    else
                    begin
                        n_next     = inc_out;
                        rd_addr    = inc_out[hua_pkg::IDX_W-1:0];
                        state_next = S_ARUN;
                    end
                end
                else
                begin
                    // occupied: skip the run, or step past the blocking unit
                    i_next = (state_reg == S_AHEAD) ? add_sum : inc_out;
                    if (i_next < unit_lim)
                    begin
                        rd_addr    = i_next[hua_pkg::IDX_W-1:0];
                        state_next = S_AHEAD;
                    end
                    else
                    begin
                        res_next.status         = hua_pkg::ST_NOMEM;
                        res_next.granted_offset = '0;
                        state_next              = S_DONE;
                    end
                end
            end
            S_MARK:
            begin
                we                                   = 1'b1;
                valid_next[k_reg[hua_pkg::IDX_W-1:0]] = 1'b1;
                k_next                               = k_inc;
                if (k_inc == end_reg)
                begin
                    res_next.status         = hua_pkg::ST_OK;
                    res_next.granted_offset =
                        hua_pkg::OFF_W'({i_reg, {hua_pkg::UNIT_SHIFT{1'b0}}});
                    state_next              = S_DONE;
                end
            end
            S_FHEAD:
            begin
                res_next.status         = hua_pkg::ST_OK;
                res_next.granted_offset = '0;
                if (entry == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    end_next   = add_sum;
                    state_next = S_FCLR;
                end
            end
            S_FCLR:
            begin
                valid_next[k_reg[hua_pkg::IDX_W-1:0]] = 1'b0;
                k_next                               = k_inc;
                if (k_inc == end_reg || k_inc >= unit_lim)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rdv_reg   <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        end_reg  <= end_next;
        want_reg <= want_next;
        res_reg  <= res_next;
    end

    assign stat.idle   = (state_reg == S_IDLE);
    assign stat.done   = (state_reg == S_DONE);
    assign stat.result = res_reg;

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg != S_IDLE))
        else $error("start did not leave idle");

    a_mark_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (k_reg < end_reg && end_reg <= unit_lim))
        else $error("mark index outside run");

    a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_reg.status != hua_pkg::ST_OK)
        |-> (res_reg.granted_offset == '0))
        else $error("offset on failed request");

    a_valid_set_by_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_MARK) |=> ((valid_reg & ~$past(valid_reg)) == '0))
        else $error("map entry became valid outside mark");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !take) |=> (state_reg == S_DONE && $stable(res_reg)))
        else $error("result changed before taken");

endmodule

@@ rtl/heap_unit_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// heap_unit_allocator_unit
// First-fit allocator over a map of fixed size heap units.
// ----------------------------------------------------------------------------
//  channel  | signals                    | beat
//  req      | req_valid, req_stall, req  | kind, request_bytes, block_offset
//  rsp      | rsp_valid, rsp_stall, rsp  | status, granted_offset
//
//  allocate walks the map entries from unit 0, then marks each unit of the run;
//  free reads the head entry, then clears each unit of its run; a bad pointer is answered without a map read
//  the map sequencer handles one beat at a time through one map read port
//  reset frees every unit at once through per-entry valid bits
//  req_stall is high while a beat is in work; a finished result waits in the
//  sequencer while rsp is full and stalled, and no new beat is taken meanwhile
// ----------------------------------------------------------------------------
module heap_unit_allocator_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hua_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output hua_pkg::rsp_t rsp
);

    hua_pkg::ctrl_stat_t stat;
    logic                start;
    logic                take;
    logic                rsp_valid_reg, rsp_valid_next;
    hua_pkg::rsp_t       rsp_reg, rsp_next;

    assign req_stall = !stat.idle;
    assign start     = req_valid && !req_stall;
    assign take      = stat.done && (!rsp_valid_reg || !rsp_stall);

    hua_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .take  (take),
        .stat  (stat)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = stat.result;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ dv/hua_reply_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hua_reply_checker
// Watches the request and reply channels of the heap unit allocator, keeps a
// private copy of the unit map, predicts each reply in order and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module hua_reply_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  hua_pkg::req_t  req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  hua_pkg::rsp_t  rsp,
    output int             fail_count,
    output int             outstanding
);

    logic [hua_pkg::ENTRY_W-1:0] heap_map [hua_pkg::UNIT_COUNT];
    hua_pkg::rsp_t               reply_q [$];

    assign outstanding = reply_q.size();

    function automatic hua_pkg::rsp_t predict_reply(hua_pkg::req_t b);
        hua_pkg::rsp_t r;
        int   want;
        int   i;
        int   n;
        int   off;
        int   first;
        int   cnt;
        r.status = hua_pkg::ST_OK;
        r.granted_offset = '0;
        if (b.kind == hua_pkg::KIND_ALLOC)
        begin
            want = (int'(b.request_bytes) + hua_pkg::UNIT_BYTES - 1) / hua_pkg::UNIT_BYTES;
            r.status = hua_pkg::ST_NOMEM;
            i = 0;
            while (i < hua_pkg::UNIT_COUNT)
            begin
                if (heap_map[i] == '0)
                begin
                    n = i;
                    while (n < i + want && n < hua_pkg::UNIT_COUNT && heap_map[n] == '0)
                        n++;
                    if (n == i + want)
                    begin
                        for (int k = i; k < n; k++)
                            heap_map[k] = hua_pkg::ENTRY_W'(n - k);
                        r.status = hua_pkg::ST_OK;
                        r.granted_offset = hua_pkg::OFF_W'(i * hua_pkg::UNIT_BYTES);
                        i = hua_pkg::UNIT_COUNT;
                    end
                    else
                        i = n + 1;
                end
                else
                    i += int'(heap_map[i]);
            end
        end
        else
        begin
            off = int'(b.block_offset);
            if (off >= hua_pkg::HEAP_BYTES || off % hua_pkg::UNIT_BYTES != 0)
                r.status = hua_pkg::ST_BADPTR;
            else
            begin
                first = off / hua_pkg::UNIT_BYTES;
                cnt = int'(heap_map[first]);
                for (int k = first; k < first + cnt && k < hua_pkg::UNIT_COUNT; k++)
                    heap_map[k] = '0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hua_pkg::rsp_t want_rsp;
        if (!rst_n)
        begin
            for (int k = 0; k < hua_pkg::UNIT_COUNT; k++)
                heap_map[k] = '0;
            reply_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%t unexpected reply beat: status %0d offset %0d",
                                 $realtime, rsp.status, rsp.granted_offset);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want_rsp = reply_q.pop_front();
                    if (rsp.status != want_rsp.status ||
                        rsp.granted_offset != want_rsp.granted_offset)
                    begin
                        if (fail_count < 10)
                            $display("%t reply mismatch: status %0d/%0d offset %0d/%0d",
                                     $realtime, want_rsp.status, rsp.status,
                                     want_rsp.granted_offset, rsp.granted_offset);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
                reply_q.push_back(predict_reply(req));
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the heap unit allocator: a directed walk through full heap,
// oversize requests, frees inside runs and bad pointers, then random traffic
// that mostly frees blocks it was granted, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    hua_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_stall;
    hua_pkg::rsp_t  rsp;
    int             fail_count;
    int             outstanding;
    logic           calm;

    logic                      kind_q [$];
    logic [hua_pkg::OFF_W-1:0] live_q [$];

    heap_unit_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    hua_reply_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic hua_pkg::req_t mk_beat(logic kind, int bytes, int off);
        hua_pkg::req_t b;
        b.kind = kind;
        b.request_bytes = (kind == hua_pkg::KIND_ALLOC) ?
                          hua_pkg::BYTES_W'(bytes) : hua_pkg::BYTES_W'($urandom);
        b.block_offset  = (kind == hua_pkg::KIND_FREE) ?
                          hua_pkg::BYTES_W'(off) : hua_pkg::BYTES_W'($urandom);
        return b;
    endfunction

    task automatic send_beat(hua_pkg::req_t b);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        kind_q.push_back(b.kind);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // offsets granted by the block, used to free real runs
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall && kind_q.size() > 0)
        begin
            if (kind_q.pop_front() == hua_pkg::KIND_ALLOC && rsp.status == hua_pkg::ST_OK)
                live_q.push_back(rsp.granted_offset);
        end
    end

    initial
    begin
        int len;
        rsp_stall <= 1'b0;
        forever
        begin
            len = calm ? 0 : idle_len();
            if (len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        hua_pkg::req_t b;
        int   r;
        int   s;
        int   idx;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        calm = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 0, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, hua_pkg::HEAP_BYTES, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 0, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 1, 0));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 65535, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 1, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, hua_pkg::UNIT_BYTES, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, hua_pkg::UNIT_BYTES + 1, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 300, 0));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 3 * hua_pkg::UNIT_BYTES));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, hua_pkg::UNIT_BYTES, 0));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, hua_pkg::UNIT_BYTES + 2));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, hua_pkg::HEAP_BYTES));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 65535));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, hua_pkg::HEAP_BYTES - hua_pkg::UNIT_BYTES));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, hua_pkg::UNIT_BYTES));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 0, 0));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 0));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 2 * hua_pkg::UNIT_BYTES));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 4 * hua_pkg::UNIT_BYTES));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 7 * hua_pkg::UNIT_BYTES));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, hua_pkg::HEAP_BYTES - hua_pkg::UNIT_BYTES, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, 2 * hua_pkg::UNIT_BYTES, 0));
        send_beat(mk_beat(hua_pkg::KIND_ALLOC, hua_pkg::UNIT_BYTES, 0));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, 0));
        send_beat(mk_beat(hua_pkg::KIND_FREE, 0, hua_pkg::HEAP_BYTES - hua_pkg::UNIT_BYTES));
        drain();
        live_q.delete();

        for (int n = 0; n < 450; n++)
        begin
            calm = (n >= 150 && n < 210);
            if (n == 300)
                drain();
            r = $urandom_range(0, 99);
            b.request_bytes = hua_pkg::BYTES_W'($urandom);
            b.block_offset  = hua_pkg::BYTES_W'($urandom);
            if (r < 48)
            begin
                b.kind = hua_pkg::KIND_ALLOC;
                s = $urandom_range(0, 99);
                if (s < 70)
                    b.request_bytes = hua_pkg::BYTES_W'($urandom_range(0, 1024));
                else if (s < 90)
                    b.request_bytes = hua_pkg::BYTES_W'($urandom_range(0, hua_pkg::HEAP_BYTES));
            end
            else if (r < 88 && live_q.size() > 0)
            begin
                b.kind = hua_pkg::KIND_FREE;
                idx = $urandom_range(0, live_q.size() - 1);
                b.block_offset = hua_pkg::BYTES_W'(live_q[idx]);
                live_q.delete(idx);
            end
            else
            begin
                b.kind = hua_pkg::KIND_FREE;
                if ($urandom_range(0, 1) == 1)
                    b.block_offset = hua_pkg::BYTES_W'(hua_pkg::UNIT_BYTES *
                                     $urandom_range(0, hua_pkg::UNIT_COUNT - 1));
            end
            send_beat(b);
        end

        calm = 1'b0;
        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ heap_unit_allocator_unit.f @@
rtl/hua_pkg.sv
rtl/hua_ram.sv
rtl/hua_ctrl.sv
rtl/heap_unit_allocator_unit.sv
dv/hua_reply_checker.sv
dv/tb.sv
